// ===== rtl/csvft_pkg.sv =====
// Shared constants, types and helpers of the CSV field tokenizer.
`default_nettype none

package csvft_pkg;

  // Depth of the delayed-whitespace buffer of an unquoted field.
  localparam int PENDING_DEPTH = 16;
  localparam int PEND_IDX_W    = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int PEND_CNT_W    = $clog2(PENDING_DEPTH + 1);

  // Parser modes.
  localparam logic [2:0] MODE_BETWEEN  = 3'd0;
  localparam logic [2:0] MODE_UNQUOTED = 3'd1;
  localparam logic [2:0] MODE_QUOTED   = 3'd2;
  localparam logic [2:0] MODE_QSEEN    = 3'd3;
  localparam logic [2:0] MODE_AFTER    = 3'd4;
  localparam logic [2:0] MODE_DISCARD  = 3'd5;

  // Result kinds.
  localparam logic [1:0] KIND_CHAR  = 2'd0;
  localparam logic [1:0] KIND_EOF   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Error codes.
  localparam logic [1:0] ERR_TEXT_AFTER = 2'd0;
  localparam logic [1:0] ERR_UNMATCHED  = 2'd1;
  localparam logic [1:0] ERR_OVERFLOW   = 2'd2;

  // Characters of interest.
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;

  // Source of the next result loaded into the output register.
  localparam logic [1:0] SEL_FLUSH = 2'd0;
  localparam logic [1:0] SEL_RES1  = 2'd1;
  localparam logic [1:0] SEL_RES2  = 2'd2;

  typedef struct packed {
    logic                  accept;
    logic                  load;
    logic [1:0]            sel;
    logic [PEND_IDX_W-1:0] flush_idx;
    logic                  last;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [PEND_CNT_W-1:0] flush_n;
    logic                  has_r1;
    logic                  has_r2;
    logic                  out_free;
  } dp_status_t;

  function automatic logic is_white(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_NL) || (c == CH_TAB);
  endfunction

endpackage

`default_nettype wire

// ===== rtl/csvft_ctrl.sv =====
// Sequencing controller: accepts bytes and steps through each byte's results.
`default_nettype none

module csvft_ctrl
  import csvft_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       byte_valid,
  output logic            byte_ready,
  input  wire dp_status_t status,
  output ctrl_cmd_t       cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_FLUSH = 2'd1;
  localparam logic [1:0] ST_RES1  = 2'd2;
  localparam logic [1:0] ST_RES2  = 2'd3;

  logic [1:0]            state, state_next;
  logic [PEND_CNT_W-1:0] flush_cnt, flush_cnt_next;
  logic [PEND_CNT_W-1:0] flush_total, flush_total_next;
  logic                  r1_v, r1_v_next;
  logic                  r2_v, r2_v_next;
  logic                  cnt_last, last_one, load, accept;

  assign cnt_last = (PEND_CNT_W'(flush_cnt + 1'b1) == flush_total);

  always_comb begin
    unique case (state)
      ST_FLUSH: last_one = cnt_last && !r1_v && !r2_v;
      ST_RES1:  last_one = !r2_v;
      ST_RES2:  last_one = 1'b1;
      default:  last_one = 1'b0;
    endcase
  end

  assign load       = (state != ST_IDLE) && status.out_free;
  assign byte_ready = (state == ST_IDLE) || (last_one && status.out_free);
  assign accept     = byte_valid && byte_ready;

  always_comb begin
    state_next       = state;
    flush_cnt_next   = flush_cnt;
    flush_total_next = flush_total;
    r1_v_next        = r1_v;
    r2_v_next        = r2_v;
    if (load) begin
      unique case (state)
        ST_FLUSH: begin
          if (!cnt_last) begin
            flush_cnt_next = PEND_CNT_W'(flush_cnt + 1'b1);
          end else if (r1_v) begin
            state_next = ST_RES1;
          end else if (r2_v) begin
            state_next = ST_RES2;
          end else begin
            state_next = ST_IDLE;
          end
        end
        ST_RES1: state_next = r2_v ? ST_RES2 : ST_IDLE;
        ST_RES2: state_next = ST_IDLE;
        default: state_next = ST_IDLE;
      endcase
    end
    if (accept) begin
      flush_cnt_next   = '0;
      flush_total_next = status.flush_n;
      r1_v_next        = status.has_r1;
      r2_v_next        = status.has_r2;
      priority if (status.flush_n != '0) begin
        state_next = ST_FLUSH;
      end else if (status.has_r1) begin
        state_next = ST_RES1;
      end else if (status.has_r2) begin
        state_next = ST_RES2;
      end else begin
        state_next = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      flush_cnt   <= '0;
      flush_total <= '0;
      r1_v        <= 1'b0;
      r2_v        <= 1'b0;
    end else begin
      state       <= state_next;
      flush_cnt   <= flush_cnt_next;
      flush_total <= flush_total_next;
      r1_v        <= r1_v_next;
      r2_v        <= r2_v_next;
    end
  end

  always_comb begin
    cmd.accept    = accept;
    cmd.load      = load;
    cmd.flush_idx = flush_cnt[PEND_IDX_W-1:0];
    cmd.last      = last_one;
    unique case (state)
      ST_FLUSH: cmd.sel = SEL_FLUSH;
      ST_RES2:  cmd.sel = SEL_RES2;
      default:  cmd.sel = SEL_RES1;
    endcase
  end

  // A new byte is only taken when the previous one has no result left to load.
  a_accept_when_done: assert property (@(posedge clk) disable iff (rst)
    accept |-> (state == ST_IDLE) || (load && last_one))
    else $error("byte accepted while results of the previous byte remain");

  a_flush_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FLUSH) |-> (flush_cnt < flush_total))
    else $error("flush index beyond the number of delayed bytes");

  a_flush_continues: assert property (@(posedge clk) disable iff (rst)
    (load && (state == ST_FLUSH) && !cnt_last) |=> (state == ST_FLUSH))
    else $error("flush left before all delayed bytes were sent");

endmodule

`default_nettype wire

// ===== rtl/csvft_dp.sv =====
// Datapath: parser state, whitespace buffer, byte decoder and output register.
`default_nettype none

module csvft_dp
  import csvft_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic [7:0] data_byte,
  input  wire logic       line_end,
  input  wire ctrl_cmd_t  cmd,
  output dp_status_t      status,
  output logic            result_valid,
  input  wire logic       result_ready,
  output logic [1:0]      kind,
  output logic [7:0]      char_out,
  output logic            end_of_record,
  output logic [1:0]      error_code,
  output logic            last_result
);

  // Parser state.
  logic [2:0]            mode, mode_next;
  logic                  content_seen, content_seen_next;
  logic [PEND_CNT_W-1:0] pend_count, pend_count_next;
  logic [7:0]            pend_mem [PENDING_DEPTH];

  // Results of the byte now being emitted.
  logic [1:0] r1_kind, r1_kind_next;
  logic [7:0] r1_char, r1_char_next;
  logic       r1_eor, r1_eor_next;
  logic [1:0] r1_code, r1_code_next;
  logic [1:0] r2_kind, r2_kind_next;
  logic       r2_eor, r2_eor_next;
  logic [1:0] r2_code, r2_code_next;

  // Decoder working signals.
  logic                  handled, unq_go, push, failed;
  logic [1:0]            fail_code;
  logic                  mid_v, tail_v, tail_eor;
  logic [1:0]            mid_kind, tail_kind, tail_code;
  logic [7:0]            mid_char;
  logic [PEND_CNT_W-1:0] flush_n;
  logic                  out_free;

  always_comb begin
    mode_next         = mode;
    content_seen_next = content_seen;
    pend_count_next   = pend_count;
    handled           = 1'b0;
    unq_go            = 1'b0;
    push              = 1'b0;
    failed            = 1'b0;
    fail_code         = ERR_TEXT_AFTER;
    mid_v             = 1'b0;
    mid_kind          = KIND_CHAR;
    mid_char          = data_byte;
    tail_v            = 1'b0;
    tail_kind         = KIND_EOF;
    tail_eor          = 1'b1;
    tail_code         = ERR_TEXT_AFTER;
    flush_n           = '0;

    // A quote seen inside a quoted field is resolved by the byte after it.
    if (mode == MODE_QSEEN) begin
      if (data_byte == CH_QUOTE) begin
        mid_v     = 1'b1;
        mid_char  = CH_QUOTE;
        mode_next = MODE_QUOTED;
        handled   = 1'b1;
      end else begin
        mode_next = MODE_AFTER;
      end
    end

    if (!handled) begin
      case (mode_next)
        MODE_UNQUOTED: begin
          if (data_byte == CH_COMMA) begin
            mid_v           = 1'b1;
            mid_kind        = KIND_EOF;
            mode_next       = MODE_BETWEEN;
            pend_count_next = '0;
          end else begin
            unq_go = 1'b1;
          end
        end
        MODE_QUOTED: begin
          if (data_byte == CH_QUOTE) begin
            mode_next = MODE_QSEEN;
          end else begin
            mid_v = 1'b1;
          end
        end
        MODE_AFTER: begin
          if (data_byte == CH_COMMA) begin
            mid_v     = 1'b1;
            mid_kind  = KIND_EOF;
            mode_next = MODE_BETWEEN;
          end else if (data_byte != CH_SPACE) begin
            failed    = 1'b1;
            fail_code = ERR_TEXT_AFTER;
          end
        end
        MODE_DISCARD: begin
        end
        default: begin
          if (data_byte == CH_QUOTE) begin
            mode_next = MODE_QUOTED;
          end else if (data_byte == CH_COMMA) begin
            mid_v    = 1'b1;
            mid_kind = KIND_EOF;
          end else if (data_byte != CH_SPACE) begin
            mode_next         = MODE_UNQUOTED;
            content_seen_next = 1'b0;
            pend_count_next   = '0;
            unq_go            = 1'b1;
          end
        end
      endcase
    end

    // Body byte of an unquoted field: delay inner whitespace, or flush it.
    if (unq_go) begin
      if (is_white(data_byte)) begin
        if (content_seen_next && !line_end) begin
          if (pend_count_next >= PEND_CNT_W'(PENDING_DEPTH)) begin
            failed    = 1'b1;
            fail_code = ERR_OVERFLOW;
          end else begin
            push            = 1'b1;
            pend_count_next = PEND_CNT_W'(pend_count_next + 1'b1);
          end
        end
      end else begin
        flush_n           = pend_count_next;
        pend_count_next   = '0;
        mid_v             = 1'b1;
        content_seen_next = 1'b1;
      end
    end

    if (failed) begin
      tail_v            = 1'b1;
      tail_kind         = KIND_ERROR;
      tail_code         = fail_code;
      mode_next         = line_end ? MODE_BETWEEN : MODE_DISCARD;
      pend_count_next   = '0;
      content_seen_next = 1'b0;
    end else if (line_end) begin
      if (mode_next == MODE_QUOTED) begin
        tail_v    = 1'b1;
        tail_kind = KIND_ERROR;
        tail_code = ERR_UNMATCHED;
      end else if (mode_next != MODE_DISCARD) begin
        tail_v = 1'b1;
      end
      mode_next         = MODE_BETWEEN;
      pend_count_next   = '0;
      content_seen_next = 1'b0;
    end
  end

  // First and second non-flush results of the byte.
  always_comb begin
    r1_kind_next = mid_v ? mid_kind : tail_kind;
    r1_char_next = (mid_v && (mid_kind == KIND_CHAR)) ? mid_char : 8'h00;
    r1_eor_next  = mid_v ? 1'b0 : tail_eor;
    r1_code_next = mid_v ? ERR_TEXT_AFTER : tail_code;
    r2_kind_next = tail_kind;
    r2_eor_next  = tail_eor;
    r2_code_next = tail_code;
  end

  assign out_free        = !result_valid || result_ready;
  assign status.flush_n  = flush_n;
  assign status.has_r1   = mid_v || tail_v;
  assign status.has_r2   = mid_v && tail_v;
  assign status.out_free = out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_BETWEEN;
      content_seen <= 1'b0;
      pend_count   <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cmd.accept) begin
        mode         <= mode_next;
        content_seen <= content_seen_next;
        pend_count   <= pend_count_next;
      end
      if (cmd.load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // Payload registers and the whitespace buffer.
  always_ff @(posedge clk) begin
    if (cmd.accept && push) begin
      pend_mem[pend_count[PEND_IDX_W-1:0]] <= data_byte;
    end
    if (cmd.accept) begin
      r1_kind <= r1_kind_next;
      r1_char <= r1_char_next;
      r1_eor  <= r1_eor_next;
      r1_code <= r1_code_next;
      r2_kind <= r2_kind_next;
      r2_eor  <= r2_eor_next;
      r2_code <= r2_code_next;
    end
    if (cmd.load) begin
      last_result <= cmd.last;
      unique case (cmd.sel)
        SEL_FLUSH: begin
          kind          <= KIND_CHAR;
          char_out      <= pend_mem[cmd.flush_idx];
          end_of_record <= 1'b0;
          error_code    <= ERR_TEXT_AFTER;
        end
        SEL_RES2: begin
          kind          <= r2_kind;
          char_out      <= 8'h00;
          end_of_record <= r2_eor;
          error_code    <= r2_code;
        end
        default: begin
          kind          <= r1_kind;
          char_out      <= r1_char;
          end_of_record <= r1_eor;
          error_code    <= r1_code;
        end
      endcase
    end
  end

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    pend_count <= PEND_CNT_W'(PENDING_DEPTH))
    else $error("whitespace count exceeds buffer depth");

  a_load_into_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> out_free)
    else $error("output register overwritten before it was taken");

  a_discard_empty: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_DISCARD) |-> (pend_count == '0))
    else $error("whitespace held while discarding a failed line");

endmodule

`default_nettype wire

// ===== rtl/csv_field_tokenizer_unit.sv =====
// A byte's first result goes from the result registers or the buffer into the output register.
// A byte has up to 18 results; all pass through the single output register, which loads one
// result per cycle while it is free, and delayed whitespace is replayed from the buffer
// the same way, one entry per cycle, before the next character.
// Reset is synchronous and active high; it clears the parser state and the sequencer,
// but not the whitespace buffer, whose entries are only read after being written.
`default_nettype none

module csv_field_tokenizer_unit
  import csvft_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  // Input bytes of one line, with line_end on the final byte.
  input  wire logic       byte_valid,
  output logic            byte_ready,
  input  wire logic [7:0] data_byte,
  input  wire logic       line_end,
  // Result beats.
  output logic            result_valid,
  input  wire logic       result_ready,
  output logic [1:0]      kind,
  output logic [7:0]      char_out,
  output logic            end_of_record,
  output logic [1:0]      error_code,
  output logic            last_result
);

  // The controller decides when a byte beat is taken and which result is loaded
  // into the output register each cycle. The datapath decodes the byte against the
  // parser mode when it is taken, stores up to two results of its own and the
  // count of delayed whitespace bytes that must be replayed ahead of them.
  ctrl_cmd_t  cmd;
  dp_status_t status;

  // A new byte may be taken in the same cycle as the last result of the previous
  // byte is loaded, so bytes with a single result stream at one per cycle while the
  // output register is free; a waiting result there holds up the input unless idle.
  csvft_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .status     (status),
    .cmd        (cmd)
  );

  // The datapath holds the parser mode, the content flag, the whitespace buffer
  // and the output register. The buffer is read straight into the output
  // register, so a replayed whitespace byte is loaded like any other result.
  csvft_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .data_byte     (data_byte),
    .line_end      (line_end),
    .cmd           (cmd),
    .status        (status),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .kind          (kind),
    .char_out      (char_out),
    .end_of_record (end_of_record),
    .error_code    (error_code),
    .last_result   (last_result)
  );

endmodule

`default_nettype wire
